// ===== rtl/pal_pkg.sv =====
package pal_pkg;

  // Field widths of one request and one result
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned HANDLE_W = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_INIT    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CREATE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DESTROY = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SETKEEP = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PURGE   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

  // Bit positions in one flag memory entry
  localparam int unsigned FLAG_PARK = 0;
  localparam int unsigned FLAG_KEEP = 1;
  localparam int unsigned FLAG_W    = 2;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [HANDLE_W-1:0] handle;
    logic                keep;
  } pal_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] granted;
    logic [COUNT_W-1:0]  free_left;
    logic [COUNT_W-1:0]  live_count;
    logic [COUNT_W-1:0]  released;
  } pal_rsp_t;

endpackage

// ===== rtl/pal_ram.sv =====
module pal_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pal_ctrl.sv =====
module pal_ctrl
  import pal_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_busy_o,
  input  pal_req_t                        req_i,
  output logic                            rsp_valid_o,
  input  logic                            rsp_ready_i,
  output pal_rsp_t                        rsp_o,
  output logic                            h_we_o,
  output logic [$clog2(POOL_SIZE):0]      h_waddr_o,
  output logic [$clog2(POOL_SIZE)-1:0]    h_wdata_o,
  output logic [$clog2(POOL_SIZE):0]      h_raddr_o,
  input  logic [$clog2(POOL_SIZE)-1:0]    h_rdata_i,
  output logic                            f_we_o,
  output logic [$clog2(POOL_SIZE)-1:0]    f_waddr_o,
  output logic [FLAG_W-1:0]               f_wdata_o,
  output logic [$clog2(POOL_SIZE)-1:0]    f_raddr_o,
  input  logic [FLAG_W-1:0]               f_rdata_i
);

  localparam int unsigned HW   = $clog2(POOL_SIZE);
  localparam int unsigned CW   = $clog2(POOL_SIZE + 1);
  localparam int unsigned CMPW = (HW > HANDLE_W) ? HW : HANDLE_W;
  localparam logic [CW-1:0] POOL_CNT = CW'(POOL_SIZE);
  localparam logic [CW-1:0] LAST_IDX = CW'(POOL_SIZE - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CREATE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_FREE,
    S_KEEP,
    S_PURGE,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  pal_req_t             req_q, req_d;
  logic [CW-1:0]        top_q, top_d;
  logic [CW-1:0]        total_q, total_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        pidx_q, pidx_d;
  logic [CW-1:0]        hit_q, hit_d;
  logic [CW-1:0]        released_q, released_d;
  logic                 pend_q, pend_d;
  logic                 keep_q, keep_d;
  logic                 init_rsp_q, init_rsp_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [HANDLE_W-1:0]  granted_q, granted_d;

  logic [CW-1:0]        top_m1;
  logic [CW-1:0]        total_m1;
  logic [HW-1:0]        h_idx;
  logic                 in_pool;
  logic                 match;

  assign top_m1   = top_q - 1'b1;
  assign total_m1 = total_q - 1'b1;
  assign h_idx    = HW'(req_q.handle);
  assign in_pool  = 32'(req_i.handle) < 32'(POOL_SIZE);
  assign match    = pend_q && (CMPW'(h_rdata_i) == CMPW'(req_q.handle));

  // Sequence one request through the two memories
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    top_d      = top_q;
    total_d    = total_q;
    cnt_d      = cnt_q;
    pidx_d     = pidx_q;
    hit_d      = hit_q;
    released_d = released_q;
    pend_d     = pend_q;
    keep_d     = keep_q;
    init_rsp_d = init_rsp_q;
    status_d   = status_q;
    granted_d  = granted_q;
    h_we_o     = 1'b0;
    h_waddr_o  = '0;
    h_wdata_o  = '0;
    h_raddr_o  = {1'b0, top_m1[HW-1:0]};
    f_we_o     = 1'b0;
    f_waddr_o  = '0;
    f_wdata_o  = '0;
    f_raddr_o  = h_idx;

    unique case (state_q)
      // Refill the free stack in handle order and clear all flags
      S_CLEAR: begin
        h_we_o    = 1'b1;
        h_waddr_o = {1'b0, cnt_q[HW-1:0]};
        h_wdata_o = cnt_q[HW-1:0];
        f_we_o    = 1'b1;
        f_waddr_o = cnt_q[HW-1:0];
        f_wdata_o = '0;
        if (cnt_q == LAST_IDX) begin
          cnt_d      = '0;
          top_d      = POOL_CNT;
          total_d    = '0;
          init_rsp_d = 1'b0;
          state_d    = init_rsp_q ? S_RESP : S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // Take a request and start its sequence; create reads the stack top here
      S_IDLE: begin
        f_raddr_o = HW'(req_i.handle);
        if (req_valid_i) begin
          req_d      = req_i;
          status_d   = ST_OK;
          granted_d  = '0;
          released_d = '0;
          cnt_d      = '0;
          pend_d     = 1'b0;
          unique case (req_i.func)
            FN_INIT: begin
              init_rsp_d = 1'b1;
              state_d    = S_CLEAR;
            end
            FN_CREATE: begin
              if (top_q != '0 && total_q < POOL_CNT) begin
                state_d = S_CREATE;
              end else begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end
            end
            FN_DESTROY: begin
              if (in_pool && total_q != '0) begin
                state_d = S_SCAN;
              end else begin
                status_d = ST_NOT_ACTIVE;
                state_d  = S_RESP;
              end
            end
            FN_SETKEEP: begin
              state_d = in_pool ? S_KEEP : S_RESP;
            end
            FN_PURGE: begin
              state_d = S_PURGE;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      // Append the popped handle to the active list and clear its flags
      S_CREATE: begin
        h_we_o    = 1'b1;
        h_waddr_o = {1'b1, total_q[HW-1:0]};
        h_wdata_o = h_rdata_i;
        f_we_o    = 1'b1;
        f_waddr_o = h_rdata_i;
        f_wdata_o = '0;
        granted_d = HANDLE_W'(h_rdata_i);
        top_d     = top_m1;
        total_d   = total_q + 1'b1;
        state_d   = S_RESP;
      end

      // Walk the active list, one read issued and one compare per cycle
      S_SCAN: begin
        h_raddr_o = {1'b1, cnt_q[HW-1:0]};
        if (match) begin
          hit_d   = pidx_q;
          pend_d  = 1'b0;
          state_d = S_MOVE_RD;
        end else if (cnt_q < total_q) begin
          pend_d = 1'b1;
          pidx_d = cnt_q;
          cnt_d  = cnt_q + 1'b1;
        end else begin
          pend_d   = 1'b0;
          status_d = ST_NOT_ACTIVE;
          state_d  = S_RESP;
        end
      end

      // Fetch the last live entry and the flags of the handle
      S_MOVE_RD: begin
        h_raddr_o = {1'b1, total_m1[HW-1:0]};
        f_raddr_o = h_idx;
        state_d   = S_MOVE_WR;
      end

      // Fill the gap with the last entry
      S_MOVE_WR: begin
        h_we_o    = 1'b1;
        h_waddr_o = {1'b1, hit_q[HW-1:0]};
        h_wdata_o = h_rdata_i;
        total_d   = total_m1;
        keep_d    = f_rdata_i[FLAG_KEEP];
        state_d   = S_FREE;
      end

      // Park a kept handle, otherwise push it on the free stack
      S_FREE: begin
        if (keep_q) begin
          f_we_o    = 1'b1;
          f_waddr_o = h_idx;
          f_wdata_o = '1;
        end else if (top_q < POOL_CNT) begin
          h_we_o    = 1'b1;
          h_waddr_o = {1'b0, top_q[HW-1:0]};
          h_wdata_o = h_idx;
          top_d     = top_q + 1'b1;
        end
        state_d = S_RESP;
      end

      // Write the keep flag, hold the parked flag
      S_KEEP: begin
        f_we_o               = 1'b1;
        f_waddr_o            = h_idx;
        f_wdata_o[FLAG_KEEP] = req_q.keep;
        f_wdata_o[FLAG_PARK] = f_rdata_i[FLAG_PARK];
        state_d              = S_RESP;
      end

      // Sweep all handles in ascending order and free the parked ones
      S_PURGE: begin
        f_raddr_o = cnt_q[HW-1:0];
        if (pend_q && f_rdata_i[FLAG_PARK]) begin
          f_we_o     = 1'b1;
          f_waddr_o  = pidx_q[HW-1:0];
          f_wdata_o  = '0;
          released_d = released_q + 1'b1;
          if (top_q < POOL_CNT) begin
            h_we_o    = 1'b1;
            h_waddr_o = {1'b0, top_q[HW-1:0]};
            h_wdata_o = pidx_q[HW-1:0];
            top_d     = top_q + 1'b1;
          end
        end
        if (cnt_q < POOL_CNT) begin
          pend_d = 1'b1;
          pidx_d = cnt_q;
          cnt_d  = cnt_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_RESP;
        end
      end

      // Hold the result until the output register takes it
      S_RESP: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      req_q      <= '0;
      top_q      <= POOL_CNT;
      total_q    <= '0;
      cnt_q      <= '0;
      pidx_q     <= '0;
      hit_q      <= '0;
      released_q <= '0;
      pend_q     <= 1'b0;
      keep_q     <= 1'b0;
      init_rsp_q <= 1'b0;
      status_q   <= ST_OK;
      granted_q  <= '0;
    end else begin
      state_q    <= state_d;
      req_q      <= req_d;
      top_q      <= top_d;
      total_q    <= total_d;
      cnt_q      <= cnt_d;
      pidx_q     <= pidx_d;
      hit_q      <= hit_d;
      released_q <= released_d;
      pend_q     <= pend_d;
      keep_q     <= keep_d;
      init_rsp_q <= init_rsp_d;
      status_q   <= status_d;
      granted_q  <= granted_d;
    end
  end

  assign req_busy_o         = (state_q != S_IDLE);
  assign rsp_valid_o        = (state_q == S_RESP);
  assign rsp_o.status       = status_q;
  assign rsp_o.granted      = granted_q;
  assign rsp_o.free_left    = COUNT_W'(top_q);
  assign rsp_o.live_count   = COUNT_W'(total_q);
  assign rsp_o.released     = COUNT_W'(released_q);

endmodule

// ===== rtl/pool_allocator_active_list.sv =====
// Request time: destroy takes longer the further into the active list its entry lies, as the
// scan reads the active list memory one entry per cycle; a miss scans the whole list,
// unless the list is empty or the handle lies outside the pool; purge sweeps every handle
// and init clears the whole pool.
// Requests: one at a time; the next is taken once the result has gone to the output register.
// Reset: a clearing pass refills the free stack and clears the flags.
module pool_allocator_active_list
  import pal_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pal_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pal_rsp_t out_rsp_o
);

  localparam int unsigned HW     = $clog2(POOL_SIZE);
  localparam int unsigned HDEPTH = 2 ** (HW + 1);

  logic          busy;
  logic          rsp_valid;
  logic          rsp_ready;
  pal_rsp_t      rsp;
  logic          h_we;
  logic [HW:0]   h_waddr;
  logic [HW-1:0] h_wdata;
  logic [HW:0]   h_raddr;
  logic [HW-1:0] h_rdata;
  logic          f_we;
  logic [HW-1:0] f_waddr;
  logic [FLAG_W-1:0] f_wdata;
  logic [HW-1:0] f_raddr;
  logic [FLAG_W-1:0] f_rdata;
  logic          out_valid_q, out_valid_d;
  pal_rsp_t      out_rsp_q, out_rsp_d;

  // Free stack in the lower half, active list in the upper half
  pal_ram #(
    .DEPTH (HDEPTH),
    .WIDTH (HW)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // Keep and parked flags, one entry per handle
  pal_ram #(
    .DEPTH (POOL_SIZE),
    .WIDTH (FLAG_W)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  pal_ctrl #(
    .POOL_SIZE (POOL_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_busy_o  (busy),
    .req_i       (in_req_i),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .h_we_o      (h_we),
    .h_waddr_o   (h_waddr),
    .h_wdata_o   (h_wdata),
    .h_raddr_o   (h_raddr),
    .h_rdata_i   (h_rdata),
    .f_we_o      (f_we),
    .f_waddr_o   (f_waddr),
    .f_wdata_o   (f_wdata),
    .f_raddr_o   (f_raddr),
    .f_rdata_i   (f_rdata)
  );

  // Output register: load a new result when empty or being drained
  assign rsp_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
      out_rsp_d   = rsp;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_rsp_q   <= out_rsp_d;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== bench/pal_checker.sv =====
module pal_checker
  import pal_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  pal_req_t             in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  pal_rsp_t             out_rsp_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o,
  output logic [POOL_SIZE-1:0] live_map_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_MAX = 10;

  // Shadow of the pool state
  logic [HANDLE_W-1:0] free_stack [POOL_SIZE];
  logic [HANDLE_W-1:0] live_list  [POOL_SIZE];
  int unsigned         free_top;
  int unsigned         live_total;
  logic [POOL_SIZE-1:0] keep_bits;
  logic [POOL_SIZE-1:0] park_bits;

  pal_rsp_t    rsp_expected_q [$];
  int unsigned fail_total;

  // Refill the free stack in handle order and clear every flag
  function automatic void refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      free_stack[i] = HANDLE_W'(i);
    end
    free_top   = POOL_SIZE;
    live_total = 0;
    keep_bits  = '0;
    park_bits  = '0;
  endfunction

  // Push a handle back; drop it when the stack is already full
  function automatic void free_handle(logic [HANDLE_W-1:0] h);
    if (free_top < POOL_SIZE) begin
      free_stack[free_top] = h;
      free_top++;
    end
  endfunction

  // Apply one request to the shadow state and return the result it causes
  function automatic pal_rsp_t predict_response(pal_req_t req);
    pal_rsp_t    rsp;
    logic        found;
    int unsigned slot;
    rsp        = '0;
    rsp.status = ST_OK;
    case (req.func)
      FN_INIT: begin
        refill_pool();
      end
      FN_CREATE: begin
        if (free_top > 0 && live_total < POOL_SIZE) begin
          free_top--;
          rsp.granted            = free_stack[free_top];
          keep_bits[rsp.granted] = 1'b0;
          park_bits[rsp.granted] = 1'b0;
          live_list[live_total]  = rsp.granted;
          live_total++;
        end else begin
          rsp.status = ST_EMPTY;
        end
      end
      FN_DESTROY: begin
        found = 1'b0;
        slot  = 0;
        for (int i = 0; i < live_total; i++) begin
          if (!found && live_list[i] == req.handle) begin
            found = 1'b1;
            slot  = i;
          end
        end
        if (found && req.handle < POOL_SIZE) begin
          // fill the gap with the last entry, then free or park
          live_list[slot] = live_list[live_total-1];
          live_total--;
          if (keep_bits[req.handle]) begin
            park_bits[req.handle] = 1'b1;
          end else begin
            free_handle(req.handle);
          end
        end else begin
          rsp.status = ST_NOT_ACTIVE;
        end
      end
      FN_SETKEEP: begin
        if (req.handle < POOL_SIZE) begin
          keep_bits[req.handle] = req.keep;
        end
      end
      FN_PURGE: begin
        for (int i = 0; i < POOL_SIZE; i++) begin
          if (park_bits[i]) begin
            park_bits[i] = 1'b0;
            keep_bits[i] = 1'b0;
            free_handle(HANDLE_W'(i));
            rsp.released = rsp.released + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.free_left  = COUNT_W'(free_top);
    rsp.live_count = COUNT_W'(live_total);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pal_rsp_t             want;
    pal_rsp_t             got;
    logic [POOL_SIZE-1:0] map;
    if (!rst_ni) begin
      refill_pool();
      rsp_expected_q.delete();
      fail_total = 0;
      errors_o   <= 0;
      pending_o  <= 0;
      live_map_o <= '0;
    end else begin
      // Check a delivered result against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        got = out_rsp_i;
        if (rsp_expected_q.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_MAX) begin
            $display("%0t: result with nothing expected: status %0d granted %0d free %0d live %0d released %0d",
                     $realtime, got.status, got.granted, got.free_left, got.live_count,
                     got.released);
          end
        end else begin
          want = rsp_expected_q.pop_front();
          if (got.status !== want.status || got.granted !== want.granted ||
              got.free_left !== want.free_left || got.live_count !== want.live_count ||
              got.released !== want.released) begin
            fail_total++;
            if (fail_total <= REPORT_MAX) begin
              $display("%0t: result mismatch: expected status %0d granted %0d free %0d live %0d released %0d",
                       $realtime, want.status, want.granted, want.free_left, want.live_count,
                       want.released);
              $display("%0t:                  actual   status %0d granted %0d free %0d live %0d released %0d",
                       $realtime, got.status, got.granted, got.free_left, got.live_count,
                       got.released);
            end
          end
        end
      end
      // Predict the result of an accepted request
      if (in_valid_i && !in_stall_i) begin
        rsp_expected_q.push_back(predict_response(in_req_i));
        map = '0;
        for (int i = 0; i < live_total; i++) begin
          map[live_list[i]] = 1'b1;
        end
        live_map_o <= map;
      end
      errors_o  <= fail_total;
      pending_o <= rsp_expected_q.size();
    end
  end

endmodule

// ===== bench/tb_pool_allocator_active_list.sv =====
module tb_pool_allocator_active_list
  import pal_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL         = 64;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned MAX_WAIT     = 7;
  localparam logic [FUNC_W-1:0] FN_CODE_MAX = {FUNC_W{1'b1}};

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pal_req_t in_req;
  logic     out_valid;
  logic     out_stall;
  pal_rsp_t out_rsp;

  int unsigned     errors;
  int unsigned     pending;
  logic [POOL-1:0] live_map;

  logic        quiet;
  int unsigned sent_total = 0;
  int unsigned cycles = 0;

  pool_allocator_active_list #(
    .POOL_SIZE(POOL)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  pal_checker #(
    .POOL_SIZE(POOL)
  ) result_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_req_i   (in_req),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_i  (out_rsp),
    .errors_o   (errors),
    .pending_o  (pending),
    .live_map_o (live_map)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pool_allocator_active_list test failed");
      $finish;
    end
  end

  // Stall the result side for a random number of cycles before each result
  initial begin : result_sink
    int unsigned hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [HANDLE_W-1:0] h,
                              input logic kv);
    int unsigned gap;
    pal_req_t    req;
    gap        = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    req.func   = fn;
    req.handle = h;
    req.keep   = kv;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req   <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_total++;
  endtask

  // Mostly pick a handle that is live, sometimes any handle
  function automatic logic [HANDLE_W-1:0] pick_live_handle();
    int unsigned         live_n;
    int unsigned         k;
    logic [HANDLE_W-1:0] h;
    live_n = $countones(live_map);
    h      = HANDLE_W'($urandom_range(0, POOL - 1));
    if (live_n != 0 && $urandom_range(0, 4) != 0) begin
      k = $urandom_range(0, live_n - 1);
      for (int i = 0; i < POOL; i++) begin
        if (live_map[i]) begin
          if (k == 0) h = HANDLE_W'(i);
          k = k - 1;
        end
      end
    end
    return h;
  endfunction

  function automatic logic [HANDLE_W-1:0] any_handle();
    return HANDLE_W'($urandom_range(0, POOL - 1));
  endfunction

  initial begin : stimulus
    int unsigned base;
    int unsigned kind;
    int unsigned len;
    int unsigned roll;
    int unsigned steps;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    quiet    <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: create three, park the middle one, then miss on destroy
    send_request(FN_INIT, '0, 1'b0);
    send_request(FN_CREATE, '0, 1'b0);
    send_request(FN_CREATE, '1, 1'b1);
    send_request(FN_CREATE, '0, 1'b0);
    send_request(FN_SETKEEP, HANDLE_W'(POOL - 2), 1'b1);
    send_request(FN_DESTROY, HANDLE_W'(POOL - 2), 1'b0);
    send_request(FN_DESTROY, HANDLE_W'(POOL - 2), 1'b0);
    // keep flag on a handle that is not live, destroy of a free handle
    send_request(FN_SETKEEP, '0, 1'b1);
    send_request(FN_SETKEEP, '0, 1'b0);
    send_request(FN_DESTROY, '0, 1'b0);
    // remove the first entry, then the last one
    send_request(FN_DESTROY, '1, 1'b0);
    send_request(FN_DESTROY, HANDLE_W'(POOL - 3), 1'b0);
    // purge the parked handle, then purge with nothing parked
    send_request(FN_PURGE, '0, 1'b0);
    send_request(FN_PURGE, '1, 1'b1);
    // create clears a keep flag left on a free handle
    send_request(FN_SETKEEP, '1, 1'b1);
    send_request(FN_CREATE, '0, 1'b0);
    send_request(FN_CREATE, '0, 1'b0);
    send_request(FN_CREATE, '0, 1'b0);
    send_request(FN_DESTROY, '1, 1'b0);
    // unused function codes leave the state alone
    for (int f = FN_PURGE + 1; f <= FN_CODE_MAX; f++) begin
      send_request(FUNC_W'(f), any_handle(), 1'($urandom_range(0, 1)));
    end
    send_request(FN_INIT, '1, 1'b1);

    // Random episodes; the first one is a fill
    base = sent_total;
    kind = 0;
    while (sent_total - base < RANDOM_ITEMS) begin
      quiet <= ($urandom_range(0, 3) == 0);
      if (kind <= 2) begin
        // fill: optional init, then a run of creates with a few keep writes
        if ($urandom_range(0, 1) != 0) send_request(FN_INIT, any_handle(), 1'b0);
        len = $urandom_range(40, 72);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) begin
            send_request(FN_SETKEEP, pick_live_handle(), 1'($urandom_range(0, 1)));
          end else begin
            send_request(FN_CREATE, any_handle(), 1'($urandom_range(0, 1)));
          end
        end
      end else if (kind <= 4) begin
        // drain: destroy live handles until none are left or 80 destroys are sent, then purge
        steps = 0;
        while (live_map != '0 && steps < 80) begin
          send_request(FN_DESTROY, pick_live_handle(), 1'($urandom_range(0, 1)));
          steps++;
        end
        send_request(FN_PURGE, any_handle(), 1'($urandom_range(0, 1)));
      end else begin
        // churn: mixed traffic with some noise
        len = $urandom_range(30, 60);
        repeat (len) begin
          roll = $urandom_range(0, 99);
          if (roll < 35) begin
            send_request(FN_CREATE, any_handle(), 1'($urandom_range(0, 1)));
          end else if (roll < 70) begin
            send_request(FN_DESTROY, pick_live_handle(), 1'($urandom_range(0, 1)));
          end else if (roll < 85) begin
            send_request(FN_SETKEEP, pick_live_handle(), 1'($urandom_range(0, 1)));
          end else if (roll < 93) begin
            send_request(FN_PURGE, any_handle(), 1'($urandom_range(0, 1)));
          end else if (roll < 97) begin
            send_request(FUNC_W'($urandom_range(FN_PURGE + 1, FN_CODE_MAX)), any_handle(),
                         1'($urandom_range(0, 1)));
          end else begin
            send_request(FN_INIT, any_handle(), 1'($urandom_range(0, 1)));
          end
        end
      end
      kind = $urandom_range(0, 9);
    end
    in_valid <= 1'b0;

    // Wait for every outstanding result, then watch for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("pool_allocator_active_list test passed");
    end else begin
      $display("pool_allocator_active_list test failed");
    end
    $finish;
  end

endmodule
